// ----- hw/rtl/rtcat_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the RTC alarm time adder.
// No dependencies; imported by every module of the block.

package rtcat_pkg;

  // Time reading as delivered by the RTC, all fields BCD
  typedef struct packed {
    logic [7:0] century_bcd;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } time_t;

  // Alarm time result, all fields BCD
  typedef struct packed {
    logic [7:0] alarm_century_bcd;
    logic [7:0] alarm_year_bcd;
    logic [4:0] alarm_month_bcd;
    logic [5:0] alarm_day_bcd;
    logic [5:0] alarm_hour_bcd;
    logic [6:0] alarm_minute_bcd;
    logic [6:0] alarm_second_bcd;
  } alarm_t;

  // Binary calendar state handed from the front half to the back half
  typedef struct packed {
    logic [7:0]  century;    // decoded, up to 165
    logic [7:0]  year;       // decoded, up to 165
    logic [4:0]  month;      // decoded, up to 25
    logic [4:0]  month_len;  // days in current month
    logic [5:0]  day;        // day plus whole-day carry, up to 47
    logic [16:0] tod;        // seconds of day, below 86400
  } cal_t;

  localparam int unsigned INTERVAL_W     = 16;
  localparam int unsigned SEC_PER_MIN    = 60;
  localparam int unsigned SEC_PER_HOUR   = 3600;
  localparam int unsigned SEC_PER_DAY    = 86400;
  localparam int unsigned YEARS_PER_CENT = 100;

  // floor(x / d) == (x * RECIP) >> SHIFT over the needed input range
  localparam int unsigned HOUR_RECIP = 74566;  // x < 86400
  localparam int unsigned HOUR_SHIFT = 28;
  localparam int unsigned MIN_RECIP  = 4370;   // x < 3600
  localparam int unsigned MIN_SHIFT  = 18;
  localparam int unsigned TEN_RECIP  = 205;    // x < 128
  localparam int unsigned TEN_SHIFT  = 11;

  // Month numbers
  localparam logic [4:0] MON_JAN = 5'd1;
  localparam logic [4:0] MON_FEB = 5'd2;
  localparam logic [4:0] MON_MAR = 5'd3;
  localparam logic [4:0] MON_MAY = 5'd5;
  localparam logic [4:0] MON_JUL = 5'd7;
  localparam logic [4:0] MON_AUG = 5'd8;
  localparam logic [4:0] MON_OCT = 5'd10;
  localparam logic [4:0] MON_DEC = 5'd12;

  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_FEB   = 5'd28;
  localparam logic [4:0] DAYS_FEB_L = 5'd29;

  // Two BCD digits to binary; digits above 9 keep their binary weight
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] bcd);
    logic [7:0] hi;
    hi = {4'd0, bcd[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, bcd[3:0]};
  endfunction

  // Binary below 100 to two BCD digits
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] bin);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    prod     = 15'(bin) * 15'(TEN_RECIP);
    tens     = prod[TEN_SHIFT+3:TEN_SHIFT];
    tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    return {tens, 4'(bin - tens_x10)};
  endfunction

  // Gregorian month length; out-of-range months count 30 days
  function automatic logic [4:0] month_len(input logic [4:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MON_FEB: len = leap ? DAYS_FEB_L : DAYS_FEB;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC: len = DAYS_LONG;
      default: len = DAYS_SHORT;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/rtc_alarm_time_adder_top.sv -----
`timescale 1ns / 1ps
// Top level of the RTC alarm time adder: interval register, pipeline, output stage.
// Depends on rtcat_pkg, rtcat_front, rtcat_back, rtcat_skid.

// Adds the programmed interval (0 to 65535 s) to a BCD clock reading and
// returns the alarm time in BCD, carrying through Gregorian month lengths and
// leap years. One request is taken every cycle while now_stall is low; each
// result passes through six pipeline stages, the first loaded at the edge
// that accepts its request, then the output register. The pipeline advances
// as a whole while the skid entry behind the output register is empty, so up
// to one extra result is absorbed before now_stall rises. Write the interval
// only while no request is in flight.

module rtc_alarm_time_adder_top import rtcat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [INTERVAL_W-1:0] cfg_wdata,
  input  logic                  now_valid,
  output logic                  now_stall,
  input  time_t                 now,
  output logic                  alarm_valid,
  input  logic                  alarm_stall,
  output alarm_t                alarm
);

  logic [INTERVAL_W-1:0] interval;
  logic                  en;
  logic                  front_valid, back_valid;
  cal_t                  cal;
  alarm_t                result;

  // Interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= '0;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  assign now_stall = !en;

  rtcat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (now_valid),
    .now       (now),
    .interval  (interval),
    .out_valid (front_valid),
    .cal       (cal)
  );

  rtcat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .cal       (cal),
    .out_valid (back_valid),
    .result    (result)
  );

  rtcat_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (back_valid),
    .in_data   (result),
    .in_ready  (en),
    .out_valid (alarm_valid),
    .out_data  (alarm),
    .out_stall (alarm_stall)
  );

`ifndef SYNTHESIS
  // A held pipeline means the output register is occupied
  a_hold_has_output: assert property (@(posedge clk) disable iff (rst)
    !en |-> alarm_valid)
    else $error("pipeline held with empty output register");

  // The skid entry fills only behind a stalled output
  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(en) |-> $past(alarm_valid && alarm_stall))
    else $error("skid entry filled without output stall");

  // Hour, minute and second results stay in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    alarm_valid |-> (alarm.alarm_hour_bcd <= 6'h23) &&
                    (alarm.alarm_minute_bcd <= 7'h59) &&
                    (alarm.alarm_second_bcd <= 7'h59) &&
                    (alarm.alarm_minute_bcd[3:0] <= 4'd9) &&
                    (alarm.alarm_second_bcd[3:0] <= 4'd9))
    else $error("alarm time of day out of range");
`endif

endmodule

// ----- hw/rtl/rtcat_front.sv -----
`timescale 1ns / 1ps
// Front half of the alarm pipeline: BCD decode, seconds total, day split.
// Depends on rtcat_pkg.

module rtcat_front import rtcat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  time_t                 now,
  input  logic [INTERVAL_W-1:0] interval,
  output logic                  out_valid,
  output cal_t                  cal
);

  // Stage 1: decoded fields
  logic       v1;
  logic [7:0] c1, y1;
  logic [4:0] mon1;
  logic [5:0] day1, hr1;
  logic [6:0] mi1, se1;

  // Stage 2: total seconds and month length
  logic        v2;
  logic [7:0]  c2, y2;
  logic [4:0]  mon2, mlen2;
  logic [5:0]  day2;
  logic [17:0] total2;

  // Stage 3: whole days split off
  logic v3;
  cal_t cal3;

  logic [17:0] total_next;
  logic        y_round, leap;
  logic [1:0]  cent_low;
  logic [4:0]  mlen_next;
  logic [1:0]  days;
  logic [16:0] tod_next;

  // Seconds since midnight plus interval
  assign total_next = 18'(se1) + 18'(mi1) * 18'(SEC_PER_MIN)
                    + 18'(hr1) * 18'(SEC_PER_HOUR) + 18'(interval);

  // Gregorian leap test on century*100+year without forming the full year
  assign y_round   = (y1 == 8'd0) || (y1 == 8'(YEARS_PER_CENT));
  assign cent_low  = c1[1:0] + {1'b0, (y1 == 8'(YEARS_PER_CENT))};
  assign leap      = (y1[1:0] == 2'b00) && (!y_round || (cent_low == 2'b00));
  assign mlen_next = month_len(mon1, leap);

  // Total is below three days: two compares pick the day count
  always_comb begin
    if (total2 >= 18'(2 * SEC_PER_DAY)) begin
      days     = 2'd2;
      tod_next = 17'(total2 - 18'(2 * SEC_PER_DAY));
    end else if (total2 >= 18'(SEC_PER_DAY)) begin
      days     = 2'd1;
      tod_next = 17'(total2 - 18'(SEC_PER_DAY));
    end else begin
      days     = 2'd0;
      tod_next = 17'(total2);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      c1   <= bcd_to_bin(now.century_bcd);
      y1   <= bcd_to_bin(now.year_bcd);
      mon1 <= 5'(bcd_to_bin({3'd0, now.month_bcd}));
      day1 <= 6'(bcd_to_bin({2'd0, now.day_bcd}));
      hr1  <= 6'(bcd_to_bin({2'd0, now.hour_bcd}));
      mi1  <= 7'(bcd_to_bin({1'b0, now.minute_bcd}));
      se1  <= 7'(bcd_to_bin({1'b0, now.second_bcd}));

      c2     <= c1;
      y2     <= y1;
      mon2   <= mon1;
      mlen2  <= mlen_next;
      day2   <= day1;
      total2 <= total_next;

      cal3.century   <= c2;
      cal3.year      <= y2;
      cal3.month     <= mon2;
      cal3.month_len <= mlen2;
      cal3.day       <= day2 + {4'd0, days};
      cal3.tod       <= tod_next;
    end
  end

  assign out_valid = v3;
  assign cal       = cal3;

endmodule

// ----- hw/rtl/rtcat_back.sv -----
`timescale 1ns / 1ps
// Back half of the alarm pipeline: month/year carry, hour/minute split, BCD encode.
// Depends on rtcat_pkg.

module rtcat_back import rtcat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  cal_t   cal,
  output logic   out_valid,
  output alarm_t result
);

  // Stage 4: calendar carried, hour found
  logic        v4;
  logic [6:0]  cent4, yr4;
  logic [4:0]  mon4, hour4;
  logic [5:0]  day4;
  logic [16:0] tod4;

  // Stage 5: remainder within hour, calendar encoded
  logic        v5;
  logic [11:0] rem5;
  logic [7:0]  cent5, yr5;
  logic [4:0]  mon5;
  logic [5:0]  day5, hour5;

  // Stage 6: minute found
  logic        v6;
  logic [11:0] rem6;
  logic [5:0]  min6;
  logic [7:0]  cent6, yr6;
  logic [4:0]  mon6;
  logic [5:0]  day6, hour6;

  logic        carry, in_year, inc;
  logic [5:0]  day_next;
  logic [4:0]  mon_next;
  logic [7:0]  year_sum, cent_sum;
  logic        year_wrap, cent_wrap;
  logic [33:0] hour_prod;
  logic [24:0] min_prod;
  logic [5:0]  sec;

  // Seconds left within the hour
  function automatic logic [16:0] cal_rem(input logic [16:0] tod, input logic [4:0] hour);
    return tod - 17'(hour) * 17'(SEC_PER_HOUR);
  endfunction

  // At most one month boundary is crossed: day stays below 48
  assign carry    = cal.day > {1'b0, cal.month_len};
  assign in_year  = (cal.month >= MON_JAN) && (cal.month < MON_DEC);
  assign inc      = carry && !in_year;
  assign day_next = carry ? (cal.day - {1'b0, cal.month_len}) : cal.day;
  always_comb begin
    if (!carry)       mon_next = cal.month;
    else if (in_year) mon_next = cal.month + 5'd1;
    else              mon_next = MON_JAN;
  end

  // Year and century reduced mod 100 by a single compare-subtract each
  assign year_sum  = cal.year + {7'd0, inc};
  assign year_wrap = year_sum >= 8'(YEARS_PER_CENT);
  assign cent_sum  = cal.century + {7'd0, year_wrap};
  assign cent_wrap = cent_sum >= 8'(YEARS_PER_CENT);

  // Hour by reciprocal multiply
  assign hour_prod = 34'(cal.tod) * 34'(HOUR_RECIP);

  // Minute by reciprocal multiply
  assign min_prod = 25'(rem5) * 25'(MIN_RECIP);

  // Second from remainder
  assign sec = 6'(rem6 - 12'(min6) * 12'(SEC_PER_MIN));

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      cent4 <= cent_wrap ? 7'(cent_sum - 8'(YEARS_PER_CENT)) : 7'(cent_sum);
      yr4   <= year_wrap ? 7'(year_sum - 8'(YEARS_PER_CENT)) : 7'(year_sum);
      mon4  <= mon_next;
      day4  <= day_next;
      hour4 <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
      tod4  <= cal.tod;

      rem5  <= 12'(cal_rem(tod4, hour4));
      cent5 <= bin_to_bcd(cent4);
      yr5   <= bin_to_bcd(yr4);
      mon5  <= 5'(bin_to_bcd({2'd0, mon4}));
      day5  <= 6'(bin_to_bcd({1'b0, day4}));
      hour5 <= 6'(bin_to_bcd({2'd0, hour4}));

      rem6  <= rem5;
      min6  <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
      cent6 <= cent5;
      yr6   <= yr5;
      mon6  <= mon5;
      day6  <= day5;
      hour6 <= hour5;
    end
  end

  // Result toward the output register
  always_comb begin
    result.alarm_century_bcd = cent6;
    result.alarm_year_bcd    = yr6;
    result.alarm_month_bcd   = mon6;
    result.alarm_day_bcd     = day6;
    result.alarm_hour_bcd    = hour6;
    result.alarm_minute_bcd  = 7'(bin_to_bcd({1'b0, min6}));
    result.alarm_second_bcd  = 7'(bin_to_bcd({1'b0, sec}));
  end

  assign out_valid = v6;

endmodule

// ----- hw/rtl/rtcat_skid.sv -----
`timescale 1ns / 1ps
// Output register with one skid entry; upstream ready comes from a flop.
// Depends on rtcat_pkg.

module rtcat_skid import rtcat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  alarm_t in_data,
  output logic   in_ready,
  output logic   out_valid,
  output alarm_t out_data,
  input  logic   out_stall
);

  logic   skid_valid;
  alarm_t skid_data;
  logic   out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || !out_stall;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Data: skid entry drains first
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule
